@@ hw/rtl/assert_macros.svh @@
// Assertion helpers. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ hw/rtl/lept_pkg.sv @@
package lept_pkg;

   // fixed port field widths
   localparam int XY_W    = 4;
   localparam int ENTRY_W = 6;
   localparam int LEN_W   = 7;

   // request codes
   localparam logic CMD_VISIT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUSH,
      ST_READOUT
   } lept_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch cell, rewind scan pointer
      logic step_inc;    // count an accepted visit
      logic scan;        // issue next path read
      logic cut;         // truncate path after the entry just read
      logic push;        // append latched cell
      logic emit;        // send entry just read as a result
      logic emit_empty;  // send the empty-path result
   } lept_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic steps_full;
      logic count_zero;
      logic count_full;
      logic hit;
      logic rd_vld;
      logic rd_last;
      logic issue_done;
   } lept_stat_type;

endpackage

@@ hw/rtl/lept_ctrl.sv @@
module lept_ctrl
   import lept_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_cmd,
   input  lept_stat_type stat,
   output lept_ctl_type  ctl,
   output logic          busy
);

   lept_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_READ) begin
                  if (stat.count_zero) begin
                     ctl.emit_empty = 1'b1;
                  end else begin
                     ctl.load = 1'b1;
                     state_in = ST_READOUT;
                  end
               end else if (!stat.steps_full) begin
                  ctl.load     = 1'b1;
                  ctl.step_inc = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stat.rd_vld && stat.hit) begin
               ctl.cut  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.scan = 1'b1;
               if ((stat.rd_vld && stat.rd_last) || (!stat.rd_vld && stat.issue_done)) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            ctl.push = !stat.count_full;
            state_in = ST_IDLE;
         end
         ST_READOUT: begin
            ctl.scan = 1'b1;
            if (stat.rd_vld) begin
               ctl.emit = 1'b1;
               if (stat.rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ hw/rtl/lept_dp.sv @@
module lept_dp
   import lept_pkg::*;
#(
   parameter int PATH_DEPTH = 64,
   parameter int COORD_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [XY_W-1:0]     req_cell_x,
   input  logic [XY_W-1:0]     req_cell_y,
   input  lept_ctl_type        ctl,
   output lept_stat_type       stat,
   output logic                rsp_valid,
   output logic [XY_W-1:0]     rsp_out_x,
   output logic [XY_W-1:0]     rsp_out_y,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [LEN_W-1:0]    rsp_path_length,
   output logic                rsp_last,
   output logic                rsp_empty_res
);

   localparam int CW    = (COORD_BITS < XY_W) ? COORD_BITS : XY_W;
   localparam int IDX_W = $clog2(PATH_DEPTH);
   localparam int CNT_W = $clog2(PATH_DEPTH + 1);

   logic [2*CW-1:0]  path_mem_ff [PATH_DEPTH];
   logic [2*CW-1:0]  rdata_ff;
   logic [2*CW-1:0]  cell_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic             issue;
   logic             rd_last;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [XY_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [XY_W-1:0]     rsp_y_ff, rsp_y_in;
   logic [ENTRY_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;

   assign issue   = ctl.scan && (ptr_ff < count_ff);
   assign rd_last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   // path store: one write (push), one registered read (scan)
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         path_mem_ff[count_ff[IDX_W-1:0]] <= cell_ff;
      end
      if (issue) begin
         rdata_ff  <= path_mem_ff[ptr_ff[IDX_W-1:0]];
         rd_idx_ff <= ptr_ff[IDX_W-1:0];
      end
      if (ctl.load) begin
         cell_ff <= {req_cell_x[CW-1:0], req_cell_y[CW-1:0]};
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.load) begin
         ptr_in = '0;
      end else if (issue) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end

      rd_vld_in = issue;

      count_in = count_ff;
      if (ctl.cut) begin
         count_in = CNT_W'(rd_idx_ff) + CNT_W'(1);
      end else if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end

      steps_in = ctl.step_inc ? steps_ff + CNT_W'(1) : steps_ff;
   end

   always_comb begin
      rsp_valid_in = ctl.emit || ctl.emit_empty;
      rsp_x_in     = XY_W'(rdata_ff[2*CW-1:CW]);
      rsp_y_in     = XY_W'(rdata_ff[CW-1:0]);
      rsp_idx_in   = ENTRY_W'(rd_idx_ff);
      rsp_len_in   = LEN_W'(count_ff);
      rsp_last_in  = rd_last;
      rsp_empty_in = 1'b0;
      if (ctl.emit_empty) begin
         rsp_x_in     = '0;
         rsp_y_in     = '0;
         rsp_idx_in   = '0;
         rsp_len_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_idx_ff   <= rsp_idx_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   always_comb begin
      stat.steps_full = steps_ff >= CNT_W'(PATH_DEPTH);
      stat.count_zero = count_ff == '0;
      stat.count_full = count_ff >= CNT_W'(PATH_DEPTH);
      stat.hit        = rdata_ff == cell_ff;
      stat.rd_vld     = rd_vld_ff;
      stat.rd_last    = rd_last;
      stat.issue_done = ptr_ff >= count_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_res   = rsp_empty_ff;

endmodule

@@ hw/rtl/loop_erased_path_tracker.sv @@
// Loop-erased path tracker.
// Request transaction: start high while busy is low. req_cmd = CMD_VISIT
// records the cell (req_cell_x, req_cell_y); req_cmd = CMD_READ reads out
// the current path. Only the first PATH_DEPTH visits count; later ones are
// accepted and dropped.
// Visit: the stored path is scanned one entry per cycle through the single
// read port of the path memory. A hit cuts the path back to that entry,
// otherwise the cell is pushed.
// Readout: one rsp_valid strobe per entry, on consecutive cycles. The first
// strobe follows the request through the state register, the path read
// register and the result register; the final one has rsp_last set. An
// empty path gives a single transaction with rsp_empty_res and rsp_last
// set, taken in the cycle after the request.
// Results are strobed for one cycle and cannot be held off by the receiver.
// Synchronous reset empties the path and clears the visit count; no memory
// clearing pass is needed since only written entries are ever read.
module loop_erased_path_tracker
   import lept_pkg::*;
#(
   parameter int PATH_DEPTH = 64,
   parameter int COORD_BITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [XY_W-1:0]     req_cell_x,
   input  logic [XY_W-1:0]     req_cell_y,
   output logic                rsp_valid,
   output logic [XY_W-1:0]     rsp_out_x,
   output logic [XY_W-1:0]     rsp_out_y,
   output logic [ENTRY_W-1:0]  rsp_entry_index,
   output logic [LEN_W-1:0]    rsp_path_length,
   output logic                rsp_last,
   output logic                rsp_empty_res
);

`include "assert_macros.svh"

   lept_ctl_type  ctl;
   lept_stat_type stat;

   // sequencing: idle / scan / push / readout
   lept_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy)
   );

   // path memory, counters, compare and result register
   lept_dp #(
      .PATH_DEPTH (PATH_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_entry_index (rsp_entry_index),
      .rsp_path_length (rsp_path_length),
      .rsp_last        (rsp_last),
      .rsp_empty_res   (rsp_empty_res)
   );

   // empty-path result is always the final one and reports zero length
   `ASSERT_CLK(a_empty_final, clock, reset,
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_path_length == '0),
      "empty result without last or with nonzero length")

   // readout entries follow back to back in index order
   `ASSERT_CLK(a_readout_seq, clock, reset,
      rsp_valid && !rsp_last |=> rsp_valid &&
      (rsp_entry_index == $past(rsp_entry_index) + ENTRY_W'(1)),
      "readout sequence broken")

   // path never grows past the store depth
   `ASSERT_NEVER(a_len_bound, clock, reset,
      rsp_valid && (rsp_path_length > LEN_W'(PATH_DEPTH)),
      "path length beyond store depth")

   // cut and push are exclusive
   `ASSERT_NEVER(a_cut_push, clock, reset,
      ctl.cut && ctl.push,
      "cut and push in the same cycle")

endmodule
